// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the run encoder RTL.
// Each macro expands to one labeled concurrent assertion, clocked and reset-gated.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant violated");

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication violated");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ===== rtl/core/pcrre_pkg.sv =====
// Package for the per-color row run encoder: field widths, run record types,
// configuration register codes. No dependencies.
`timescale 1ns / 1ps

package pcrre_pkg;

  localparam int unsigned PIX_W     = 4;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] CNT_MAX    = 11'd2047;
  localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd320;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd240;

  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 48;

  // run queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // declared high field first so run_color lands in the low bits
  typedef struct packed {
    logic [POS_W-1:0] run_index;
    logic [POS_W-1:0] row_y;
    logic [POS_W-1:0] end_x;
    logic [POS_W-1:0] start_x;
    logic [PIX_W-1:0] run_color;
  } run_t;

  localparam int unsigned RUN_W = $bits(run_t);

  // one pixel's output: run_a always, run_b too when pair is set
  typedef struct packed {
    logic pair;
    run_t run_a;
    run_t run_b;
  } run_rec_t;

endpackage

// ===== rtl/core/pcrre_front.sv =====
// Front end of the run encoder: config registers, column/row tracking,
// per-color run counters and run record building. Depends on pcrre_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcrre_front #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned MAX_HEIGHT  = 1024,
  parameter int unsigned COLOR_COUNT = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [pcrre_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [pcrre_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                           pix_valid_i,
  input  logic [pcrre_pkg::PIX_W-1:0]    pix_color_i,
  input  logic                           q_ready_i,
  output logic                           pix_ready_o,
  output logic                           push_o,
  output pcrre_pkg::run_rec_t            rec_o
);

  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned CIW = $clog2(COLOR_COUNT);

  logic [pcrre_pkg::CFG_W-1:0] width_q, height_q;
  logic [XW-1:0]               column_q, run_start_q, run_start_n, x_last;
  logic [YW-1:0]               row_q, y_last;
  logic [pcrre_pkg::PIX_W-1:0] prev_q, prev_n, color_c;
  logic [pcrre_pkg::CNT_W-1:0] cur_cnt_q, cur_cnt_n, cnt_rd, cnt_new;
  logic [COLOR_COUNT-1:0]      valid_q, ci_hot;
  logic [pcrre_pkg::CNT_W-1:0] cnt_mem [COLOR_COUNT];
  logic [CIW-1:0]              ci;
  logic                        accept, row_start, changed, new_run, eol;
  pcrre_pkg::run_t             run_close, run_fin;

  // effective last column / row after clamping the configured size
  always_comb begin
    if (width_q == '0) begin
      x_last = '0;
    end else if (32'(width_q) > MAX_WIDTH) begin
      x_last = XW'(MAX_WIDTH - 1);
    end else begin
      x_last = XW'(32'(width_q) - 32'd1);
    end
    if (height_q == '0) begin
      y_last = '0;
    end else if (32'(height_q) > MAX_HEIGHT) begin
      y_last = YW'(MAX_HEIGHT - 1);
    end else begin
      y_last = YW'(32'(height_q) - 32'd1);
    end
  end

  always_comb begin
    if (32'(pix_color_i) >= COLOR_COUNT) begin
      color_c = pcrre_pkg::PIX_W'(COLOR_COUNT - 1);
    end else begin
      color_c = pix_color_i;
    end
  end

  assign ci          = CIW'(color_c);
  assign ci_hot      = {{(COLOR_COUNT-1){1'b0}}, 1'b1} << ci;
  assign pix_ready_o = q_ready_i;
  assign accept      = pix_valid_i && q_ready_i;
  assign row_start   = (column_q == '0);
  assign changed     = !row_start && (color_c != prev_q);
  assign new_run     = row_start || changed;
  assign eol         = (column_q >= x_last);

  // counter of a color not yet seen in this row reads as zero
  assign cnt_rd  = (valid_q[ci] && !row_start) ? cnt_mem[ci] : '0;
  assign cnt_new = (cnt_rd == pcrre_pkg::CNT_MAX) ? cnt_rd : cnt_rd + 1'b1;

  assign cur_cnt_n   = new_run ? cnt_new : cur_cnt_q;
  assign prev_n      = new_run ? color_c : prev_q;
  assign run_start_n = row_start ? '0 : (changed ? column_q : run_start_q);

  always_comb begin
    run_close.run_color = prev_q;
    run_close.start_x   = pcrre_pkg::POS_W'(run_start_q);
    run_close.end_x     = pcrre_pkg::POS_W'(column_q - 1'b1);
    run_close.row_y     = pcrre_pkg::POS_W'(row_q);
    run_close.run_index = pcrre_pkg::POS_W'(cur_cnt_q - 1'b1);

    run_fin.run_color   = prev_n;
    run_fin.start_x     = pcrre_pkg::POS_W'(run_start_n);
    run_fin.end_x       = pcrre_pkg::POS_W'(column_q);
    run_fin.row_y       = pcrre_pkg::POS_W'(row_q);
    run_fin.run_index   = pcrre_pkg::POS_W'(cur_cnt_n - 1'b1);

    if (changed) begin
      rec_o.pair  = eol;
      rec_o.run_a = run_close;
    end else begin
      rec_o.pair  = 1'b0;
      rec_o.run_a = run_fin;
    end
    rec_o.run_b = run_fin;
  end

  assign push_o = accept && (changed || eol);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= pcrre_pkg::WIDTH_RST;
      height_q <= pcrre_pkg::HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        pcrre_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        pcrre_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      row_q       <= '0;
      run_start_q <= '0;
      prev_q      <= '0;
      cur_cnt_q   <= '0;
      valid_q     <= '0;
    end else if (accept) begin
      run_start_q <= run_start_n;
      prev_q      <= prev_n;
      cur_cnt_q   <= cur_cnt_n;
      if (row_start) begin
        valid_q <= ci_hot;
      end else if (changed) begin
        valid_q <= valid_q | ci_hot;
      end
      if (eol) begin
        column_q <= '0;
        row_q    <= (row_q >= y_last) ? '0 : row_q + 1'b1;
      end else begin
        column_q <= column_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && new_run) begin
      cnt_mem[ci] <= cnt_new;
    end
  end

  `ASSERT_IMPLIES(a_run_counted, clk_i, rst_ni, column_q != '0, cur_cnt_q != '0)
  `ASSERT_NEXT(a_row_wraps, clk_i, rst_ni, accept && eol, column_q == '0)

endmodule

// ===== rtl/core/pcrre_queue.sv =====
// Two-entry run record queue decoupling the front end from the output side.
// Depends on pcrre_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcrre_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pcrre_pkg::run_rec_t rec_i,
  output logic                ready_o,
  input  logic                pop_i,
  output logic                valid_o,
  output pcrre_pkg::run_rec_t rec_o
);

  pcrre_pkg::run_rec_t                  mem_q [pcrre_pkg::Q_DEPTH];
  logic [pcrre_pkg::Q_PTR_W-1:0]        wr_ptr_q, rd_ptr_q;
  logic [pcrre_pkg::Q_CNT_W-1:0]        cnt_q;
  logic                                 full;

  assign full    = (cnt_q == pcrre_pkg::Q_CNT_W'(pcrre_pkg::Q_DEPTH));
  assign ready_o = !full;
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= rec_i;
  end

  `ASSERT_ALWAYS(a_no_overflow, clk_i, rst_ni, !(push_i && full))
  `ASSERT_ALWAYS(a_no_underflow, clk_i, rst_ni, !(pop_i && !valid_o))

endmodule

// ===== rtl/core/pcrre_back.sv =====
// Back end: splits each queued record into one or two output beats and holds
// them in the output register. Depends on pcrre_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcrre_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  pcrre_pkg::run_rec_t q_rec_i,
  output logic                q_pop_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output pcrre_pkg::run_t     m_run_o,
  output logic                m_last_o
);

  logic            out_valid_q, out_last_q, phase_q;
  pcrre_pkg::run_t out_run_q, beat;
  logic            load, take, beat_last;

  // phase_q set: first run of a pair already sent, second one next
  assign load      = !out_valid_q || m_ready_i;
  assign take      = load && q_valid_i;
  assign beat      = phase_q ? q_rec_i.run_b : q_rec_i.run_a;
  assign beat_last = phase_q || !q_rec_i.pair;
  assign q_pop_o   = take && beat_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      if (load) out_valid_q <= q_valid_i;
      if (take) phase_q <= !beat_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_run_q  <= beat;
      out_last_q <= beat_last;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_run_o   = out_run_q;
  assign m_last_o  = out_last_q;

  `ASSERT_IMPLIES(a_pair_pending, clk_i, rst_ni, out_valid_q && !out_last_q, phase_q)

endmodule

// ===== rtl/core/per_color_row_run_encoder_top.sv =====
// Top level of the per-color row run encoder. Depends on pcrre_pkg, pcrre_front,
// pcrre_queue and pcrre_back.
// A pixel beat's finished run is written into the run queue and then into the output
// register of the back end before it shows on m_axis.
// Throughput: one pixel beat per cycle while the run queue has room; a row end with a
// color change yields two output beats, and the two-entry run queue absorbs the extra.
// Reset (rst_ni low, async): column/row/run state zero, size 320 x 240, counters by valid bits.
`timescale 1ns / 1ps

module per_color_row_run_encoder_top #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned MAX_HEIGHT  = 1024,
  parameter int unsigned COLOR_COUNT = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write channel: index 0 image_width, 1 image_height
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pcrre_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [pcrre_pkg::CFG_W-1:0]      cfg_data_i,
  // pixel stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [pcrre_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,  // [3:0] pixel_color, rest pad
  // run stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [3:0] run_color, [13:4] start_x, [23:14] end_x, [33:24] row_y,
  // [43:34] run_index, [47:44] zero
  output logic [pcrre_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  output logic                             m_axis_tlast_o    // last_result
);

  localparam int unsigned PAD_W = pcrre_pkg::M_TDATA_W - pcrre_pkg::RUN_W;

  logic                push, q_ready, q_valid, q_pop;
  pcrre_pkg::run_rec_t push_rec, head_rec;
  pcrre_pkg::run_t     out_run;

  // config writes are always taken; user must keep the block idle when they arrive, unenforced
  assign cfg_ready_o = 1'b1;

  // front: classifies each pixel and builds the run(s) it finishes
  pcrre_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .COLOR_COUNT (COLOR_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .pix_valid_i (s_axis_tvalid_i),
    .pix_color_i (s_axis_tdata_i[pcrre_pkg::PIX_W-1:0]),
    .q_ready_i   (q_ready),
    .pix_ready_o (s_axis_tready_o),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  // queue: lets the pixel side run on while the output side is stalled, until it fills
  pcrre_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rec_o   (head_rec)
  );

  // back: one beat per run, output register toward the sink
  pcrre_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_rec_i   (head_rec),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_run_o   (out_run),
    .m_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{PAD_W{1'b0}}, out_run};

endmodule

// ===== tb/sv/per_color_row_run_encoder_top_tb.sv =====
// Self-checking bench for per_color_row_run_encoder_top: a directed table, then random
// pixel streams under several sizes and backpressure mixes, checked by a local predictor.
// Depends on pcrre_pkg and the RTL of the run encoder.
`timescale 1ns / 1ps

module per_color_row_run_encoder_top_tb;

  localparam int unsigned MAX_W      = 1024;
  localparam int unsigned MAX_H      = 1024;
  localparam int unsigned COLORS     = 16;
  localparam int unsigned DRAIN_CYC  = 8;   // pipe is two deep, margin on top
  localparam int unsigned PHASE_PIX  = 79;
  localparam int unsigned PHASES     = 8;

  // one expected run beat
  typedef struct {
    logic [pcrre_pkg::PIX_W-1:0] color;
    logic [pcrre_pkg::POS_W-1:0] sx;
    logic [pcrre_pkg::POS_W-1:0] ex;
    logic [pcrre_pkg::POS_W-1:0] row;
    logic [pcrre_pkg::POS_W-1:0] idx;
    logic                        last;
  } run_exp_t;

  // directed table row: a register write or a pixel; n_typed < 0 means predictor only
  typedef struct {
    bit                          is_cfg;
    pcrre_pkg::cfg_reg_e         sel;
    logic [pcrre_pkg::CFG_W-1:0] value;
    logic [pcrre_pkg::PIX_W-1:0] pix;
    int                          n_typed;
    run_exp_t                    t0;
    run_exp_t                    t1;
  } stim_row_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [pcrre_pkg::CFG_IDX_W-1:0]   cfg_addr_i;
  logic [pcrre_pkg::CFG_W-1:0]       cfg_data_i;
  logic                              s_axis_tvalid_i;
  logic                              s_axis_tready_o;
  logic [pcrre_pkg::S_TDATA_W-1:0]   s_axis_tdata_i;
  logic                              m_axis_tvalid_o;
  logic                              m_axis_tready_i;
  logic [pcrre_pkg::M_TDATA_W-1:0]   m_axis_tdata_o;
  logic                              m_axis_tlast_o;

  // predictor state and register mirror
  logic [pcrre_pkg::CFG_W-1:0]       width_q;
  logic [pcrre_pkg::CFG_W-1:0]       height_q;
  logic [pcrre_pkg::POS_W-1:0]       col_q;
  logic [pcrre_pkg::POS_W-1:0]       row_q;
  logic [pcrre_pkg::POS_W-1:0]       start_q;
  logic [pcrre_pkg::PIX_W-1:0]       prev_q;
  logic [pcrre_pkg::CNT_W-1:0]       color_runs_q [COLORS];

  run_exp_t   runs_due [$];
  stim_row_t  stim_tab [$];
  run_exp_t   blank_run;
  int         err_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  per_color_row_run_encoder_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #10 clk_i = ~clk_i;

  // hard stop, far beyond the slowest legal run
  initial begin
    #(4_000_000);
    $display("per_color_row_run_encoder_top_tb: done, errors");
    $finish;
  end

  function automatic run_exp_t mk_run(logic [pcrre_pkg::PIX_W-1:0] c,
                                      logic [pcrre_pkg::POS_W-1:0] sx,
                                      logic [pcrre_pkg::POS_W-1:0] ex,
                                      logic [pcrre_pkg::POS_W-1:0] row,
                                      logic [pcrre_pkg::POS_W-1:0] idx, logic last);
    run_exp_t r;
    r.color = c;
    r.sx    = sx;
    r.ex    = ex;
    r.row   = row;
    r.idx   = idx;
    r.last  = last;
    return r;
  endfunction

  function automatic int unsigned eff_size(logic [pcrre_pkg::CFG_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  // queue the run that closes here; index is the color's count minus one
  function automatic void close_run(logic [pcrre_pkg::PIX_W-1:0] c,
                                    logic [pcrre_pkg::POS_W-1:0] sx,
                                    logic [pcrre_pkg::POS_W-1:0] ex);
    logic [pcrre_pkg::CNT_W-1:0] n;
    n = color_runs_q[c];
    runs_due.insert(runs_due.size(),
                    mk_run(c, sx, ex, row_q, (n == 0) ? '0 : pcrre_pkg::POS_W'(n - 1), 1'b0));
  endfunction

  function automatic void bump_count(logic [pcrre_pkg::PIX_W-1:0] c);
    if (color_runs_q[c] != pcrre_pkg::CNT_MAX) color_runs_q[c] = color_runs_q[c] + 1'b1;
  endfunction

  // advance the encoder by one pixel and queue the runs it finishes
  function automatic void encode_pixel(logic [pcrre_pkg::PIX_W-1:0] pix);
    int unsigned w;
    int unsigned h;
    int          n_before;
    run_exp_t    tail;
    w = eff_size(width_q, MAX_W);
    h = eff_size(height_q, MAX_H);
    n_before = runs_due.size();
    // labels are 4 bits and COLORS is 16, so no label is out of range here
    if (col_q == 0) begin
      foreach (color_runs_q[i]) color_runs_q[i] = '0;
      prev_q  = pix;
      start_q = '0;
      bump_count(pix);
    end else if (pix != prev_q) begin
      close_run(prev_q, start_q, col_q - 1'b1);
      start_q = col_q;
      prev_q  = pix;
      bump_count(pix);
    end
    // a size shrunk mid-row ends the row at the next pixel
    if (col_q >= w - 1) begin
      close_run(prev_q, start_q, col_q);
      col_q = '0;
      row_q = (row_q >= h - 1) ? '0 : row_q + 1'b1;
    end else begin
      col_q = col_q + 1'b1;
    end
    if (runs_due.size() > n_before) begin
      tail = runs_due.pop_back();
      tail.last = 1'b1;
      runs_due.insert(runs_due.size(), tail);
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $realtime, what);
    err_count++;
  endtask

  // receiver backpressure, redrawn every cycle
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // run beat checker
  always @(posedge clk_i) begin : check_runs
    run_exp_t        e;
    pcrre_pkg::run_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[pcrre_pkg::RUN_W-1:0];
      if (runs_due.size() == 0) begin
        report_mismatch($sformatf("run beat with nothing pending, tdata %h", m_axis_tdata_o));
      end else begin
        e = runs_due.pop_front();
        if (got.run_color !== e.color)
          report_mismatch($sformatf("run_color %0d, want %0d", got.run_color, e.color));
        if (got.start_x !== e.sx)
          report_mismatch($sformatf("start_x %0d, want %0d", got.start_x, e.sx));
        if (got.end_x !== e.ex)
          report_mismatch($sformatf("end_x %0d, want %0d", got.end_x, e.ex));
        if (got.row_y !== e.row)
          report_mismatch($sformatf("row_y %0d, want %0d", got.row_y, e.row));
        if (got.run_index !== e.idx)
          report_mismatch($sformatf("run_index %0d, want %0d", got.run_index, e.idx));
        if (m_axis_tlast_o !== e.last)
          report_mismatch($sformatf("tlast %b, want %b", m_axis_tlast_o, e.last));
        if (m_axis_tdata_o[pcrre_pkg::M_TDATA_W-1:pcrre_pkg::RUN_W] !== '0)
          report_mismatch($sformatf("tdata pad %h not zero", m_axis_tdata_o));
      end
    end
  end

  // register write; enters and leaves on a falling edge with valid low at exit
  task automatic cfg_write(input pcrre_pkg::cfg_reg_e sel,
                           input logic [pcrre_pkg::CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= sel;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (sel == pcrre_pkg::REG_IMAGE_WIDTH) width_q = value;
    else height_q = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // one pixel beat; tvalid is left high so back-to-back beats need no gap
  task automatic send_pixel(input stim_row_t r);
    int n_before;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(pcrre_pkg::S_TDATA_W-pcrre_pkg::PIX_W){1'b0}}, r.pix};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    n_before = runs_due.size();
    encode_pixel(r.pix);
    // typed rows replace what the predictor queued for this beat
    if (r.n_typed >= 0) begin
      while (runs_due.size() > n_before) void'(runs_due.pop_back());
      if (r.n_typed > 0) runs_due.insert(runs_due.size(), r.t0);
      if (r.n_typed > 1) runs_due.insert(runs_due.size(), r.t1);
    end
    @(negedge clk_i);
  endtask

  // stop the pixel stream and wait for every pending run, then let the pipe settle
  task automatic wait_runs_drained();
    s_axis_tvalid_i <= 1'b0;
    while (runs_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  function automatic void add_cfg(pcrre_pkg::cfg_reg_e sel, logic [pcrre_pkg::CFG_W-1:0] value);
    stim_row_t r;
    r.is_cfg  = 1'b1;
    r.sel     = sel;
    r.value   = value;
    r.pix     = '0;
    r.n_typed = -1;
    stim_tab.insert(stim_tab.size(), r);
  endfunction

  function automatic void add_pix(logic [pcrre_pkg::PIX_W-1:0] pix, int n, run_exp_t a,
                                  run_exp_t b);
    stim_row_t r;
    r.is_cfg  = 1'b0;
    r.sel     = pcrre_pkg::REG_IMAGE_WIDTH;
    r.value   = '0;
    r.pix     = pix;
    r.n_typed = n;
    r.t0      = a;
    r.t1      = b;
    stim_tab.insert(stim_tab.size(), r);
  endfunction

  initial begin : main
    stim_row_t                   r;
    logic [pcrre_pkg::PIX_W-1:0] last_pix;
    int                          pick;
    int unsigned                 ph_w [PHASES];
    int unsigned                 ph_h [PHASES];

    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_addr_i      = pcrre_pkg::REG_IMAGE_WIDTH;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    width_q         = pcrre_pkg::WIDTH_RST;
    height_q        = pcrre_pkg::HEIGHT_RST;
    col_q           = '0;
    row_q           = '0;
    start_q         = '0;
    prev_q          = '0;
    foreach (color_runs_q[i]) color_runs_q[i] = '0;
    blank_run       = mk_run('0, '0, '0, '0, '0, 1'b0);

    // reset size 320 x 240: a color change mid-row closes the first run
    add_pix(4'd7, -1, blank_run, blank_run);
    add_pix(4'd7, -1, blank_run, blank_run);
    add_pix(4'd0, 1, mk_run(4'd7, 10'd0, 10'd1, 10'd0, 10'd0, 1'b1), blank_run);
    // zero width acts as one column; column 3 is past it, so the row ends at once
    add_cfg(pcrre_pkg::REG_IMAGE_WIDTH, 11'd0);
    add_cfg(pcrre_pkg::REG_IMAGE_HEIGHT, 11'd2);
    add_pix(4'd0, 1, mk_run(4'd0, 10'd2, 10'd3, 10'd0, 10'd0, 1'b1), blank_run);
    add_pix(4'd15, 1, mk_run(4'd15, 10'd0, 10'd0, 10'd1, 10'd0, 1'b1), blank_run);
    add_pix(4'd9, 1, mk_run(4'd9, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1), blank_run);
    // 3-wide, one row: color change on the last column gives a pair of runs
    add_cfg(pcrre_pkg::REG_IMAGE_WIDTH, 11'd3);
    add_cfg(pcrre_pkg::REG_IMAGE_HEIGHT, 11'd1);
    add_pix(4'd5, -1, blank_run, blank_run);
    add_pix(4'd5, -1, blank_run, blank_run);
    add_pix(4'd6, 2, mk_run(4'd5, 10'd0, 10'd1, 10'd1, 10'd0, 1'b0),
            mk_run(4'd6, 10'd2, 10'd2, 10'd1, 10'd0, 1'b1));
    add_pix(4'd3, -1, blank_run, blank_run);
    add_pix(4'd3, -1, blank_run, blank_run);
    add_pix(4'd3, 1, mk_run(4'd3, 10'd0, 10'd2, 10'd0, 10'd0, 1'b1), blank_run);
    // oversize both ways, alternating colors to climb run_index
    add_cfg(pcrre_pkg::REG_IMAGE_WIDTH, 11'd2047);
    add_cfg(pcrre_pkg::REG_IMAGE_HEIGHT, 11'd2047);
    for (int i = 0; i < 7; i++) add_pix((i % 2) ? 4'd2 : 4'd1, -1, blank_run, blank_run);
    // shrink mid-row: next pixel ends the row
    add_cfg(pcrre_pkg::REG_IMAGE_WIDTH, 11'd4);
    add_pix(4'd1, -1, blank_run, blank_run);

    ph_w = '{1024, 4, 1, 2047, 7, 2, 1025, 0};
    ph_h = '{1024, 3, 1, 2, 0, 2047, 3, 0};
    ph_w[PHASES-1] = $urandom_range(40, 1);
    ph_h[PHASES-1] = $urandom_range(6, 0);

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (stim_tab[i]) begin
      if (stim_tab[i].is_cfg) begin
        wait_runs_drained();
        cfg_write(stim_tab[i].sel, stim_tab[i].value);
      end else begin
        send_pixel(stim_tab[i]);
      end
    end

    // random part: each phase picks a size and a backpressure mix
    last_pix = '0;
    for (int p = 0; p < PHASES; p++) begin
      wait_runs_drained();
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 76;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 76;
        end
        default: begin
          send_idle_pct  = 21;
          recv_stall_pct = 21;
        end
      endcase
      cfg_write(pcrre_pkg::REG_IMAGE_WIDTH, pcrre_pkg::CFG_W'(ph_w[p]));
      cfg_write(pcrre_pkg::REG_IMAGE_HEIGHT, pcrre_pkg::CFG_W'(ph_h[p]));
      for (int k = 0; k < PHASE_PIX; k++) begin
        // mostly repeats and a small palette so runs get long and indices climb
        pick = $urandom_range(99);
        if (pick >= 55 && pick < 85) last_pix = pcrre_pkg::PIX_W'($urandom_range(3));
        else if (pick >= 85) last_pix = pcrre_pkg::PIX_W'($urandom_range(15));
        r.is_cfg  = 1'b0;
        r.sel     = pcrre_pkg::REG_IMAGE_WIDTH;
        r.value   = '0;
        r.pix     = last_pix;
        r.n_typed = -1;
        r.t0      = blank_run;
        r.t1      = blank_run;
        send_pixel(r);
      end
    end

    wait_runs_drained();
    if (err_count == 0) begin
      $display("per_color_row_run_encoder_top_tb: done, clean");
    end else begin
      $display("per_color_row_run_encoder_top_tb: done, errors");
    end
    $finish;
  end

endmodule
